// ===== hw/rtl/tcf_pkg.sv =====
// shared constants, types and the cordic arctangent table for the tilt filter
`timescale 1ns / 1ps
`default_nettype none

package tcf_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int TAB_FRAC        = 36;
    localparam int RND_SH          = TAB_FRAC - ANGLE_FRAC_BITS;
    localparam int STEP_W          = $clog2(CORDIC_STEPS);

    localparam int SAMPLE_W = 16;
    localparam int PRE_SH   = 14;
    // scaled vector plus cordic gain and the quarter turn
    localparam int VEC_W    = SAMPLE_W + PRE_SH + 3;
    // degrees in Q.36, range about +-512
    localparam int ANG_W    = TAB_FRAC + 10;
    // rounded accelerometer angle, one extra bit for the negation
    localparam int ACC_W    = ANG_W - RND_SH + 1;

    localparam int BIAS_W   = 8;
    localparam int GAIN_W   = 16;
    localparam int WEIGHT_W = 17;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W    = 32;
    // angle plus corrected rate times gain
    localparam int G_W      = OUT_W + 2;
    localparam int MB_W     = WEIGHT_W + 1;
    localparam int PROD_W   = G_W + MB_W;

    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_BIAS_HALF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_GAIN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT   = 2'd2;

    localparam logic [BIAS_W-1:0]   BIAS_RESET   = 8'd51;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd200;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd655;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;

    localparam logic [63:0] ONE_Q56 = 64'd1 << 56;

    typedef logic [63:0] atan_tab_t [CORDIC_STEPS];

    // unsigned quotient by restoring long division
    function automatic logic [63:0] const_udiv(input logic [63:0] num,
                                               input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-i) in degrees, Q.36, from arctangent series on integers
    function automatic atan_tab_t build_atan_tab();
        atan_tab_t          tab;
        logic [63:0]        n;
        logic [63:0]        nn;
        logic [63:0]        p;
        logic [63:0]        k;
        logic [63:0]        term;
        logic [63:0]        r36;
        logic signed [63:0] sum;
        logic signed [63:0] rad;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            rad = 64'sd0;
            for (int pass = 0; pass < 2; pass++)
            begin
                if (i == 0)
                begin
                    n = (pass == 0) ? 64'd5 : 64'd239;
                end
                else
                begin
                    n = 64'd1 << i;
                end
                nn  = n * n;
                p   = const_udiv(ONE_Q56, n);
                sum = 64'sd0;
                k   = 64'd0;
                while (p != 64'd0)
                begin
                    term = const_udiv(p, 64'd2 * k + 64'd1);
                    if (k[0])
                    begin
                        sum = sum - $signed(term);
                    end
                    else
                    begin
                        sum = sum + $signed(term);
                    end
                    p = const_udiv(p, nn);
                    k = k + 64'd1;
                end
                if (i == 0)
                begin
                    rad = (pass == 0) ? (sum <<< 2) : (rad - sum);
                end
                else if (pass == 0)
                begin
                    rad = sum;
                end
            end
            r36    = ($unsigned(rad) + (64'd1 << 19)) >> 20;
            tab[i] = const_udiv(r36 * 64'd18000000, 64'd314159);
        end
        return tab;
    endfunction

    localparam atan_tab_t ATAN_TAB = build_atan_tab();

endpackage

`default_nettype wire

// ===== hw/rtl/tcf_cordic.sv =====
// iterative vectoring cordic: accelerometer angle -atan2(y, x) in degrees
`timescale 1ns / 1ps
`default_nettype none

module tcf_cordic (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic signed [tcf_pkg::SAMPLE_W-1:0] y_in,
    input  wire logic signed [tcf_pkg::SAMPLE_W-1:0] x_in,
    output logic                                    done,
    output logic signed [tcf_pkg::ACC_W-1:0]        angle
);

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_RUN  = 3'b010,
        C_FIN  = 3'b100
    } cordic_state_t;

    localparam int VW = tcf_pkg::VEC_W;
    localparam int AW = tcf_pkg::ANG_W;
    localparam int SW = tcf_pkg::SAMPLE_W;
    localparam int XW = VW - SW - tcf_pkg::PRE_SH;

    cordic_state_t                   state_reg, state_next;
    logic [tcf_pkg::STEP_W-1:0]      step_reg, step_next;
    logic                            done_reg, done_next;
    logic signed [VW-1:0]            cx_reg, cx_next;
    logic signed [VW-1:0]            cy_reg, cy_next;
    logic signed [AW-1:0]            ang_reg, ang_next;
    logic                            zero_reg, zero_next;
    logic signed [tcf_pkg::ACC_W-1:0] angle_reg, angle_next;

    logic signed [VW-1:0] x_ext, y_ext, dx, dy;
    logic signed [AW-1:0] tab_step, ang90, rnd;

    assign x_ext = $signed({{XW{x_in[SW-1]}}, x_in, {tcf_pkg::PRE_SH{1'b0}}});
    assign y_ext = $signed({{XW{y_in[SW-1]}}, y_in, {tcf_pkg::PRE_SH{1'b0}}});
    assign ang90 = $signed(tcf_pkg::ATAN_TAB[0][AW-1:0]) <<< 1;

    assign dx       = cy_reg >>> step_reg;
    assign dy       = cx_reg >>> step_reg;
    assign tab_step = $signed(tcf_pkg::ATAN_TAB[step_reg][AW-1:0]);
    assign rnd      = (ang_reg + $signed({{(AW-tcf_pkg::RND_SH){1'b0}}, 1'b1,
                      {(tcf_pkg::RND_SH-1){1'b0}}})) >>> tcf_pkg::RND_SH;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        ang_next   = ang_reg;
        zero_next  = zero_reg;
        angle_next = angle_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    zero_next = (x_in == '0) && (y_in == '0);
                    step_next = '0;
                    // left half plane: turn a quarter toward positive x first
                    if (x_in < 0)
                    begin
                        if (y_in >= 0)
                        begin
                            cx_next  = y_ext;
                            cy_next  = -x_ext;
                            ang_next = ang90;
                        end
                        else
                        begin
                            cx_next  = -y_ext;
                            cy_next  = x_ext;
                            ang_next = -ang90;
                        end
                    end
                    else
                    begin
                        cx_next  = x_ext;
                        cy_next  = y_ext;
                        ang_next = '0;
                    end
                    state_next = C_RUN;
                end
            end
            C_RUN:
            begin
                if (cy_reg >= 0)
                begin
                    cx_next  = cx_reg + dx;
                    cy_next  = cy_reg - dy;
                    ang_next = ang_reg + tab_step;
                end
                else
                begin
                    cx_next  = cx_reg - dx;
                    cy_next  = cy_reg + dy;
                    ang_next = ang_reg - tab_step;
                end
                if (step_reg == tcf_pkg::STEP_W'(tcf_pkg::CORDIC_STEPS - 1))
                begin
                    state_next = C_FIN;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            C_FIN:
            begin
                angle_next = zero_reg ? '0 : -rnd[tcf_pkg::ACC_W-1:0];
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        ang_reg   <= ang_next;
        zero_reg  <= zero_next;
        angle_reg <= angle_next;
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tilt_complementary_filter_core.sv =====
// top level: tilt complementary filter with gyro integration and weighted blend
`timescale 1ns / 1ps
`default_nettype none

// Each accepted word (accel_x, accel_z, gyro_y) yields one tilt_angle word,
// signed Q16.16 degrees, blending -atan2(accel_x, accel_z) with the previous
// angle plus the bias-corrected gyro rate times gyro_gain. An item passes
// through a load step, 16 iterations of the single shift-add cordic stage,
// a rounding step, the hand-over of the angle, then two passes through the
// shared 34x18 multiplier and a final add and saturate. in_ready is low
// from acceptance until the item is finished, so no new word is taken before
// then; the finished word sits in the output register while the next word is
// taken, and a word still waiting there holds the final step until it leaves.
// Configuration writes are accepted in any cycle and must only be issued
// while the block is idle.
module tilt_complementary_filter_core (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [tcf_pkg::SAMPLE_W-1:0]  accel_x,
    input  wire logic signed [tcf_pkg::SAMPLE_W-1:0]  accel_z,
    input  wire logic signed [tcf_pkg::SAMPLE_W-1:0]  gyro_y,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [tcf_pkg::OUT_W-1:0]          tilt_angle,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [tcf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [tcf_pkg::CFG_W-1:0]            cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_GYRO  = 7'b0000010,
        S_GSUM  = 7'b0000100,
        S_WAIT  = 7'b0001000,
        S_MUL_A = 7'b0010000,
        S_MUL_G = 7'b0100000,
        S_SUM   = 7'b1000000
    } tcf_state_t;

    localparam int GW  = tcf_pkg::G_W;
    localparam int PW  = tcf_pkg::PROD_W;
    localparam int OW  = tcf_pkg::OUT_W;
    localparam int AW  = tcf_pkg::ACC_W;
    localparam int SW  = tcf_pkg::SAMPLE_W;
    localparam int RW  = PW - 16;
    localparam logic signed [RW-1:0] RES_MAX = $signed({{(RW-OW+1){1'b0}}, {(OW-1){1'b1}}});
    localparam logic signed [RW-1:0] RES_MIN = $signed({{(RW-OW+1){1'b1}}, {(OW-1){1'b0}}});
    localparam logic signed [PW-1:0] ROUND_HALF = $signed({{(PW-16){1'b0}}, 16'h8000});

    tcf_state_t                            state_reg, state_next;
    logic [tcf_pkg::BIAS_W-1:0]            bias_reg;
    logic [tcf_pkg::GAIN_W-1:0]            gain_reg;
    logic [tcf_pkg::WEIGHT_W-1:0]          weight_reg;
    logic signed [SW-1:0]                  corr_reg, corr_next;
    logic signed [PW-1:0]                  prod_reg, prod_next;
    logic signed [PW-1:0]                  sum_reg, sum_next;
    logic signed [GW-1:0]                  g_reg, g_next;
    logic signed [OW-1:0]                  angle_reg, angle_next;
    logic                                  out_valid_reg, out_valid_next;

    logic                                  accept, out_free, wr_out;
    logic                                  cordic_done;
    logic signed [AW-1:0]                  acc_angle;
    logic signed [SW+1:0]                  gdiff, gadj;
    logic signed [SW:0]                    gtr;
    logic [tcf_pkg::WEIGHT_W-1:0]          w_eff, w_rest;
    logic signed [GW-1:0]                  ma;
    logic signed [tcf_pkg::MB_W-1:0]       mb;
    logic signed [PW-1:0]                  prod;
    logic signed [PW-1:0]                  total;
    logic signed [RW-1:0]                  res;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign wr_out    = (state_reg == S_SUM) && out_free;

    tcf_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .y_in  (accel_x),
        .x_in  (accel_z),
        .done  (cordic_done),
        .angle (acc_angle)
    );

    // bias correction, truncated toward zero, then saturated to 16 bits
    assign gdiff = $signed({gyro_y[SW-1], gyro_y, 1'b0}) - $signed({2'b00, bias_reg});
    assign gadj  = gdiff + $signed({{(SW+1){1'b0}}, gdiff[SW+1]});
    assign gtr   = gadj[SW+1:1];

    always_comb
    begin
        if (gtr < $signed({1'b1, 1'b1, {(SW-1){1'b0}}}))
        begin
            corr_next = $signed({1'b1, {(SW-1){1'b0}}});
        end
        else if (gtr > $signed({2'b00, {(SW-1){1'b1}}}))
        begin
            corr_next = $signed({1'b0, {(SW-1){1'b1}}});
        end
        else
        begin
            corr_next = gtr[SW-1:0];
        end
    end

    assign w_eff  = (weight_reg > tcf_pkg::WEIGHT_ONE) ? tcf_pkg::WEIGHT_ONE : weight_reg;
    assign w_rest = tcf_pkg::WEIGHT_ONE - w_eff;

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_GYRO:
            begin
                ma = $signed({{(GW-SW){corr_reg[SW-1]}}, corr_reg});
                mb = $signed({2'b00, gain_reg});
            end
            S_MUL_A:
            begin
                ma = $signed({{(GW-AW){acc_angle[AW-1]}}, acc_angle});
                mb = $signed({1'b0, w_eff});
            end
            default:
            begin
                ma = g_reg;
                mb = $signed({1'b0, w_rest});
            end
        endcase
    end

    assign prod  = ma * mb;
    assign total = sum_reg + prod_reg;
    assign res   = total[PW-1:16];

    always_comb
    begin
        state_next     = state_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        g_next         = g_reg;
        angle_next     = angle_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_GYRO;
                end
            end
            S_GYRO:
            begin
                prod_next  = prod;
                state_next = S_GSUM;
            end
            S_GSUM:
            begin
                g_next     = $signed({{(GW-OW){angle_reg[OW-1]}}, angle_reg}) + prod_reg[GW-1:0];
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (cordic_done)
                begin
                    state_next = S_MUL_A;
                end
            end
            S_MUL_A:
            begin
                prod_next  = prod;
                state_next = S_MUL_G;
            end
            S_MUL_G:
            begin
                sum_next   = prod_reg + ROUND_HALF;
                prod_next  = prod;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                // hold here while the previous word is still pending
                if (out_free)
                begin
                    if (res > RES_MAX)
                    begin
                        angle_next = RES_MAX[OW-1:0];
                    end
                    else if (res < RES_MIN)
                    begin
                        angle_next = RES_MIN[OW-1:0];
                    end
                    else
                    begin
                        angle_next = res[OW-1:0];
                    end
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            angle_reg     <= '0;
            bias_reg      <= tcf_pkg::BIAS_RESET;
            gain_reg      <= tcf_pkg::GAIN_RESET;
            weight_reg    <= tcf_pkg::WEIGHT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            angle_reg     <= angle_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tcf_pkg::CFG_GYRO_BIAS_HALF: bias_reg   <= cfg_data[tcf_pkg::BIAS_W-1:0];
                    tcf_pkg::CFG_GYRO_GAIN:      gain_reg   <= cfg_data[tcf_pkg::GAIN_W-1:0];
                    tcf_pkg::CFG_BLEND_WEIGHT:   weight_reg <= cfg_data[tcf_pkg::WEIGHT_W-1:0];
                    default:
                    begin
                        bias_reg <= bias_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            corr_reg <= corr_next;
        end
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
        g_reg    <= g_next;
    end

    assign out_valid  = out_valid_reg;
    assign tilt_angle = angle_reg;

    a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("block still ready right after taking a word");

    a_done_in_wait : assert property (@(posedge clk) disable iff (!rst_n)
        cordic_done |-> state_reg == S_WAIT)
        else $error("cordic finished outside the wait state");

    a_angle_only_on_write : assert property (@(posedge clk) disable iff (!rst_n)
        !wr_out |=> $stable(angle_reg))
        else $error("kept angle changed without an output word");

    a_valid_from_write : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(wr_out))
        else $error("output word raised without a finished item");

endmodule

`default_nettype wire
